@@ sv/ccse_pkg.sv @@
// Package for the cross cosine similarity engine: sizes, register indexes, constants.
`timescale 1ns / 1ps
`default_nettype none
package ccse_pkg;

  localparam int DEF_MAX_ROWS     = 64;
  localparam int DEF_MAX_FEATURES = 32;
  localparam int DEF_ELEMENT_BITS = 16;

  localparam int ROWS_W  = 7;   // num_rows register
  localparam int FEAT_W  = 6;   // num_features register and element counter
  localparam int ROW_W   = 6;   // row index fields
  localparam int CFG_W   = 7;
  localparam int SIM_W   = 16;
  localparam int Q_W     = 15;  // quotient magnitude, up to 1.0 in Q1.14
  localparam int FRAC_BITS = 14;

  localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(16384);

  typedef enum logic [0:0] {
    REG_NUM_ROWS     = 1'b0,
    REG_NUM_FEATURES = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

endpackage
`default_nettype wire

@@ sv/ccse_sqrt.sv @@
// Bit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ccse_sqrt #(
  parameter int IN_W  = 37,
  parameter int OUT_W = (IN_W + 1) / 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [IN_W-1:0]  radicand,
  output logic                  done,
  output logic [OUT_W-1:0]      root
);

  localparam int RAD_W = 2 * OUT_W;
  localparam int REM_W = OUT_W + 3;
  localparam int CNT_W = $clog2(OUT_W + 1);

  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [OUT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W-1:0] rem_sh, trial;

  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = REM_W'({root_r, 2'b01});
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = RAD_W'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[OUT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(OUT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

  a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("sqrt done held longer than a cycle");
  a_no_busy_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("sqrt still busy at done");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("sqrt did not start");

endmodule
`default_nettype wire

@@ sv/cross_cosine_similarity_engine_top.sv @@
// Top level: feature stores, dot/norm accumulation, bit-serial sqrt and divide.
//
//  channel | direction | ports                                       | handshake
//  in      | input     | in_func, in_end_value, in_start_value,      | in_valid/in_ready
//          |           | in_row_from, in_row_to                      |
//  out     | output    | out_similarity                              | out_valid/out_ready
//  cfg     | input     | cfg_index, cfg_wdata                        | cfg_we
//
// A query passes from accept to result through setup, one store read per
// element, a drain of the multiply pipeline, the bit-serial square roots and
// a 14-step divide, which is skipped when the result clamps to one.
// Reset is synchronous active low and clears control state only; the stores
// are not cleared. A finished result waits in the output register while loads
// keep being accepted; a second query waits in its final state until it drains.
`timescale 1ns / 1ps
`default_nettype none
module cross_cosine_similarity_engine_top
  import ccse_pkg::*;
#(
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES,
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_func,
  input  wire logic signed [ELEMENT_BITS-1:0] in_end_value,
  input  wire logic signed [ELEMENT_BITS-1:0] in_start_value,
  input  wire logic [ROW_W-1:0]               in_row_from,
  input  wire logic [ROW_W-1:0]               in_row_to,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SIM_W-1:0]             out_similarity,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [CFG_W-1:0]               cfg_wdata
);

  localparam int DEPTH  = MAX_ROWS * MAX_FEATURES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FW     = $clog2(MAX_FEATURES + 1);
  localparam int PROD_W = 2 * ELEMENT_BITS;
  localparam int DOT_W  = PROD_W + FW;
  localparam int SS_W   = PROD_W - 1 + FW;
  localparam int SQRT_W = (SS_W + 1) / 2;
  localparam int DEN_W  = 2 * SQRT_W;
  localparam int REM_W  = DEN_W + 1;
  localparam int LIM_W  = (ADDR_W + 1 > ROWS_W + FEAT_W) ? ADDR_W + 1 : ROWS_W + FEAT_W;
  localparam int CMP_W  = (DOT_W > DEN_W) ? DOT_W : DEN_W;
  localparam int DC_W   = $clog2(FRAC_BITS + 1);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SETUP = 9'b000000010,
    ST_RUN   = 9'b000000100,
    ST_DRAIN = 9'b000001000,
    ST_SQRT  = 9'b000010000,
    ST_SCALE = 9'b000100000,
    ST_CHECK = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [ROWS_W-1:0] rows_r;
  logic [FEAT_W-1:0] feats_r;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;

  // effective register values
  logic [ROWS_W-1:0]        eff_rows;
  logic [FEAT_W-1:0]        eff_feat;
  logic [LIM_W-1:0]         limit;
  logic [LIM_W-1:0]         wr_ptr_x, inc_ptr_x;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     load_acc, query_acc;

  always_comb begin
    if (rows_r == '0) eff_rows = ROWS_W'(1);
    else if (int'(rows_r) > MAX_ROWS) eff_rows = ROWS_W'(MAX_ROWS);
    else eff_rows = rows_r;
    if (feats_r == '0) eff_feat = FEAT_W'(1);
    else if (int'(feats_r) > MAX_FEATURES) eff_feat = FEAT_W'(MAX_FEATURES);
    else eff_feat = feats_r;
    limit     = LIM_W'(eff_rows) * LIM_W'(eff_feat);
    wr_ptr_x  = (LIM_W'(ptr_r) >= limit) ? '0 : LIM_W'(ptr_r);
    wr_addr   = ADDR_W'(wr_ptr_x);
    inc_ptr_x = wr_ptr_x + LIM_W'(1);
    ptr_nxt   = (inc_ptr_x >= limit) ? '0 : ADDR_W'(inc_ptr_x);
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign load_acc  = in_valid && in_ready && (in_func == FUNC_LOAD);
  assign query_acc = in_valid && in_ready && (in_func == FUNC_QUERY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= ROWS_W'(64);
      feats_r <= FEAT_W'(32);
      ptr_r   <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_NUM_ROWS) rows_r <= cfg_wdata[ROWS_W-1:0];
      if (cfg_we && cfg_index == REG_NUM_FEATURES) feats_r <= cfg_wdata[FEAT_W-1:0];
      if (load_acc) ptr_r <= ptr_nxt;
    end
  end

  // query row selection
  logic [ROW_W-1:0]  rf_r, rt_r;
  logic [ROWS_W-1:0] rf_sat, rt_sat;
  logic [ADDR_W-1:0] base_e_r, base_s_r;
  logic [FEAT_W-1:0] cnt_r;
  logic [ADDR_W-1:0] rd_addr_e, rd_addr_s;

  always_comb begin
    rf_sat = (ROWS_W'(rf_r) >= eff_rows) ? eff_rows - ROWS_W'(1) : ROWS_W'(rf_r);
    rt_sat = (ROWS_W'(rt_r) >= eff_rows) ? eff_rows - ROWS_W'(1) : ROWS_W'(rt_r);
    rd_addr_e = ADDR_W'(LIM_W'(base_e_r) + LIM_W'(cnt_r));
    rd_addr_s = ADDR_W'(LIM_W'(base_s_r) + LIM_W'(cnt_r));
  end

  // feature stores
  logic [ELEMENT_BITS-1:0] end_mem   [DEPTH];
  logic [ELEMENT_BITS-1:0] start_mem [DEPTH];
  logic signed [ELEMENT_BITS-1:0] rd_e_r, rd_s_r;

  always_ff @(posedge clk) begin
    if (load_acc) begin
      end_mem[wr_addr]   <= in_end_value;
      start_mem[wr_addr] <= in_start_value;
    end
    rd_e_r <= end_mem[rd_addr_e];
    rd_s_r <= start_mem[rd_addr_s];
  end

  // element pipeline: read, multiply, accumulate
  logic                     rd_v_r, prod_v_r;
  logic signed [PROD_W-1:0] pd_r, pe_r, ps_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic [SS_W-1:0]          sse_r, sss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= (state_r == ST_RUN);
      prod_v_r <= rd_v_r;
    end
    if (rd_v_r) begin
      pd_r <= rd_e_r * rd_s_r;
      pe_r <= rd_e_r * rd_e_r;
      ps_r <= rd_s_r * rd_s_r;
    end
    if (state_r == ST_SETUP) begin
      dot_r <= '0;
      sse_r <= '0;
      sss_r <= '0;
    end else if (prod_v_r) begin
      dot_r <= dot_r + DOT_W'(pd_r);
      sse_r <= sse_r + SS_W'($unsigned(pe_r));
      sss_r <= sss_r + SS_W'($unsigned(ps_r));
    end
  end

  // square roots of both sums of squares
  logic              sq_start;
  logic              sq_done_e, sq_done_s;
  logic [SQRT_W-1:0] root_e, root_s, norm_e, norm_s;

  assign sq_start = (state_r == ST_DRAIN) && !rd_v_r && !prod_v_r;

  ccse_sqrt #(.IN_W(SS_W), .OUT_W(SQRT_W)) u_sqrt_e (
    .clk, .rst_n, .start(sq_start), .radicand(sse_r), .done(sq_done_e), .root(root_e)
  );
  ccse_sqrt #(.IN_W(SS_W), .OUT_W(SQRT_W)) u_sqrt_s (
    .clk, .rst_n, .start(sq_start), .radicand(sss_r), .done(sq_done_s), .root(root_s)
  );

  assign norm_e = (root_e == '0) ? SQRT_W'(1) : root_e;
  assign norm_s = (root_s == '0) ? SQRT_W'(1) : root_s;

  // scale and divide
  logic [DEN_W-1:0] den_r;
  logic [DOT_W-1:0] mag_r;
  logic             neg_r;
  logic [REM_W-1:0] rem_r, rem_sh;
  logic [Q_W-1:0]   q_r;
  logic [DC_W-1:0]  dcnt_r;
  logic             out_valid_r;
  logic signed [SIM_W-1:0] sim_r, sim_nxt;

  assign rem_sh  = {rem_r[REM_W-2:0], 1'b0};
  assign sim_nxt = neg_r ? -SIM_W'(q_r) : SIM_W'(q_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (query_acc) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_RUN;
      ST_RUN:   if (cnt_r == eff_feat - FEAT_W'(1)) state_nxt = ST_DRAIN;
      ST_DRAIN: if (sq_start) state_nxt = ST_SQRT;
      ST_SQRT:  if (sq_done_e) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (CMP_W'(mag_r) >= CMP_W'(den_r)) ? ST_FIN : ST_DIV;
      ST_DIV:   if (dcnt_r == DC_W'(FRAC_BITS - 1)) state_nxt = ST_FIN;
      ST_FIN:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      dcnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == ST_RUN) cnt_r <= cnt_r + FEAT_W'(1);
      else cnt_r <= '0;
      if (state_r == ST_DIV) dcnt_r <= dcnt_r + DC_W'(1);
      else dcnt_r <= '0;
    end
    if (query_acc) begin
      rf_r <= in_row_from;
      rt_r <= in_row_to;
    end
    if (state_r == ST_SETUP) begin
      base_e_r <= ADDR_W'(LIM_W'(rf_sat) * LIM_W'(eff_feat));
      base_s_r <= ADDR_W'(LIM_W'(rt_sat) * LIM_W'(eff_feat));
    end
    if (sq_start) begin
      neg_r <= dot_r[DOT_W-1];
      mag_r <= dot_r[DOT_W-1] ? DOT_W'(-dot_r) : DOT_W'(dot_r);
    end
    if (state_r == ST_SCALE) den_r <= DEN_W'(norm_e) * DEN_W'(norm_s);
    if (state_r == ST_CHECK) begin
      rem_r <= REM_W'(mag_r);
      q_r   <= (CMP_W'(mag_r) >= CMP_W'(den_r)) ? ONE_Q14 : '0;
    end else if (state_r == ST_DIV) begin
      if (rem_sh >= REM_W'(den_r)) begin
        rem_r <= rem_sh - REM_W'(den_r);
        q_r   <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[Q_W-2:0], 1'b0};
      end
    end
    if (state_r == ST_FIN && (!out_valid_r || out_ready)) sim_r <= sim_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_similarity = sim_r;

  a_sqrt_in_sqrt_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done_e |-> (state_r == ST_SQRT && sq_done_s))
    else $error("square root finished outside its state");
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (sim_r <= 16384 && sim_r >= -16384))
    else $error("similarity out of range");
  a_ptr_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> (LIM_W'(ptr_r) < limit))
    else $error("load pointer past limit");
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside final state");

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for the cross cosine similarity engine: queued stimulus, predicted similarities.
`timescale 1ns / 1ps
module tb;
  import ccse_pkg::*;

  typedef struct {
    func_t             func;
    logic signed [15:0] ev;
    logic signed [15:0] sv;
    logic [5:0]        rf;
    logic [5:0]        rt;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic signed [15:0] in_end_value = '0;
  logic signed [15:0] in_start_value = '0;
  logic [5:0] in_row_from = '0;
  logic [5:0] in_row_to = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_similarity;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [6:0] cfg_wdata = '0;

  cross_cosine_similarity_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_end_value(in_end_value), .in_start_value(in_start_value),
    .in_row_from(in_row_from), .in_row_to(in_row_to),
    .out_valid(out_valid), .out_ready(out_ready), .out_similarity(out_similarity),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [15:0] end_mem [0:2047];
  logic signed [15:0] start_mem [0:2047];
  int unsigned load_ptr;
  logic [6:0] rows_reg = 7'd64;
  logic [5:0] feats_reg = 6'd32;

  // generator shadow, used only to keep queries on loaded rows
  bit loaded [0:2047];
  int unsigned gen_ptr;

  beat_t pending_beats[$];
  logic signed [15:0] sim_q[$];
  beat_t cur;
  int n_acc, n_loads, n_queries, n_checked, errors;
  int send_idle, recv_idle;

  function automatic int unsigned eff_rows(logic [6:0] r);
    return (r < 1) ? 1 : (r > 64 ? 64 : r);
  endfunction

  function automatic int unsigned eff_feats(logic [5:0] f);
    return (f < 1) ? 1 : (f > 32 ? 32 : f);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned norm_of(bit is_end, int unsigned base, int unsigned nf);
    longint unsigned ss, nrm;
    longint v;
    ss = 0;
    for (int k = 0; k < nf; k++) begin
      v = is_end ? end_mem[base + k] : start_mem[base + k];
      ss += v * v;
    end
    nrm = isqrt(ss);
    return (nrm == 0) ? 1 : nrm;
  endfunction

  function automatic logic signed [15:0] similarity_of(logic [5:0] rf_in, logic [5:0] rt_in);
    int unsigned nr, nf, rf, rt;
    longint dot;
    longint unsigned mag, den, q;
    nr = eff_rows(rows_reg);
    nf = eff_feats(feats_reg);
    rf = (rf_in >= nr) ? nr - 1 : rf_in;
    rt = (rt_in >= nr) ? nr - 1 : rt_in;
    dot = 0;
    for (int k = 0; k < nf; k++)
      dot += longint'(end_mem[rf*nf + k]) * longint'(start_mem[rt*nf + k]);
    mag = (dot < 0) ? -dot : dot;
    den = norm_of(1'b1, rf*nf, nf) * norm_of(1'b0, rt*nf, nf);
    q = (mag >= den) ? 16384 : (mag * 16384) / den;
    return (dot < 0) ? -16'(q) : 16'(q);
  endfunction

  task automatic apply_beat(beat_t b);
    int unsigned lim;
    if (b.func == FUNC_LOAD) begin
      lim = eff_rows(rows_reg) * eff_feats(feats_reg);
      if (load_ptr >= lim) load_ptr = 0;
      end_mem[load_ptr] = b.ev;
      start_mem[load_ptr] = b.sv;
      load_ptr++;
      if (load_ptr >= lim) load_ptr = 0;
      n_loads++;
    end else begin
      sim_q.insert(sim_q.size(), similarity_of(b.rf, b.rt));
      n_queries++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    beat_t nx;
    send_idle = (n_acc < 190) ? 9 : ((n_acc < 380) ? 60 : 0);
    recv_idle = (n_acc < 190) ? 60 : ((n_acc < 380) ? 9 : 0);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_beat(cur);
        n_acc++;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
          nx = pending_beats.pop_front();
          cur = nx;
          in_valid <= 1'b1;
          in_func <= nx.func;
          in_end_value <= nx.ev;
          in_start_value <= nx.sv;
          in_row_from <= nx.rf;
          in_row_to <= nx.rt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (sim_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual similarity %0d",
                   $time, out_similarity);
          errors++;
        end else begin
          want = sim_q.pop_front();
          n_checked++;
          if (out_similarity !== want) begin
            $display("%0t: similarity mismatch, expected %0d, actual %0d",
                     $time, want, out_similarity);
            errors++;
          end
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh0000;
      1: return 16'sh8000;
      2: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_load(logic signed [15:0] ev, logic signed [15:0] sv);
    beat_t b;
    int unsigned lim;
    lim = eff_rows(rows_reg) * eff_feats(feats_reg);
    if (gen_ptr >= lim) gen_ptr = 0;
    loaded[gen_ptr] = 1'b1;
    gen_ptr++;
    if (gen_ptr >= lim) gen_ptr = 0;
    b.func = FUNC_LOAD; b.ev = ev; b.sv = sv;
    b.rf = 6'($urandom); b.rt = 6'($urandom);
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic push_query(logic [5:0] rf, logic [5:0] rt);
    beat_t b;
    b.func = FUNC_QUERY; b.ev = 16'($urandom); b.sv = 16'($urandom);
    b.rf = rf; b.rt = rt;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  function automatic bit row_loaded(int unsigned r);
    int unsigned nr, nf;
    nr = eff_rows(rows_reg);
    nf = eff_feats(feats_reg);
    if (r >= nr) r = nr - 1;
    for (int k = 0; k < nf; k++)
      if (!loaded[r*nf + k]) return 0;
    return 1;
  endfunction

  task automatic random_beats(int n);
    int unsigned nr, rf, rt;
    int pool[$];
    nr = eff_rows(rows_reg);
    for (int i = 0; i < n; i++) begin
      pool.delete();
      for (int r = 0; r < nr; r++)
        if (row_loaded(r)) pool.insert(pool.size(), r);
      if (pool.size() == 0 || $urandom_range(99) < 55) begin
        push_load(pick_value(), pick_value());
      end else begin
        rf = pool[$urandom_range(pool.size() - 1)];
        rt = pool[$urandom_range(pool.size() - 1)];
        // rows past the region saturate to the last row
        if (nr < 64 && row_loaded(nr - 1) && $urandom_range(3) == 0)
          rf = $urandom_range(63, nr);
        if (nr < 64 && row_loaded(nr - 1) && $urandom_range(3) == 0)
          rt = $urandom_range(63, nr);
        push_query(6'(rf), 6'(rt));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_valid || sim_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_NUM_ROWS) rows_reg = val;
    else feats_reg = val[5:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  int cfg_rows [9] = '{2, 1, 0, 5, 127, 64, 3, 33, 7};
  int cfg_feats[9] = '{2, 1, 0, 7, 63, 1, 32, 4, 3};

  initial begin
    load_ptr = 0;
    gen_ptr = 0;
    for (int i = 0; i < 2048; i++) loaded[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 9; p++) begin
      write_cfg(REG_NUM_ROWS, 7'(cfg_rows[p]));
      write_cfg(REG_NUM_FEATURES, 7'(cfg_feats[p]));
      if (p == 0) begin
        // identical rows, zero row, opposite rows, full-scale values
        push_load(16'sh7FFF, 16'sh7FFF);
        push_load(16'sh8000, 16'sh8000);
        push_load(16'sh0000, -16'sh7FFF);
        push_load(16'sh0000, 16'sh7FFF);
        push_query(0, 0);
        push_query(0, 1);
        push_query(1, 0);
        push_query(1, 1);
        push_query(63, 63);
        push_load(16'sh0001, -16'sh0001);   // pointer wrapped to row 0
        push_load(16'sh0001, -16'sh0001);
        push_query(0, 0);
        push_query(0, 1);
      end
      random_beats(60);
      wait_drained();
    end
    $display("covered %0d beats: %0d loads, %0d queries, %0d similarities checked",
             n_acc, n_loads, n_queries, n_checked);
    $display("nine register settings including out-of-range and extreme values");
    if (errors == 0 && sim_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout waiting for results");
    $display("TB_ERROR");
    $finish;
  end

endmodule
